/* hw/rtl/sfv_pkg.sv */
`timescale 1ns / 1ps
// Package for the record validator with the Fletcher-16 check.
// It holds the field widths, the header layout and the configuration register indexes.
// It has no dependencies.
package sfv_pkg;

    localparam int unsigned HEADER_BYTES_DEF = 32;
    localparam int unsigned POS_W = 21;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SUM_W = 8;
    localparam logic [SUM_W-1:0] FLETCHER_MOD = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_LENGTH  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        HDR_MAGIC    = 2'd0,
        HDR_VERSION  = 2'd1,
        HDR_LENGTH   = 2'd2,
        HDR_CHECKSUM = 2'd3
    } hdr_word_t;

    // Adds two values modulo 255; the first is below 255 and the second at most 255.
    function automatic logic [SUM_W-1:0] mod255_add(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FLETCHER_MOD})
        begin
            s = s - {1'b0, FLETCHER_MOD};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

/* hw/rtl/superblock_fletcher16_validator_unit.sv */
`timescale 1ns / 1ps
// The verdict is registered and shown in the cycle after the byte marked last is accepted.
// Throughput: one byte per cycle. The input stalls only when a last byte arrives
// while an earlier verdict is still held and stalled at the output.
// The position counter, the Fletcher sums and the header capture registers are
// updated in a single register stage. Reset clears all of them, the configuration
// registers and the output valid flag.
module superblock_fletcher16_validator_unit #(
    parameter int unsigned HEADER_BYTES = sfv_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sfv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            end_of_record,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     computed_sum,
    output logic                            header_match,
    output logic                            sum_match,
    output logic                            record_valid,
    output logic                            stream_short
);

    localparam int unsigned PW = sfv_pkg::POS_W;
    localparam int unsigned WW = sfv_pkg::WORD_W;
    localparam int unsigned SW = sfv_pkg::SUM_W;

    logic [WW-1:0] exp_magic_reg;
    logic [WW-1:0] exp_version_reg;
    logic [PW-1:0] pay_len_reg;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [SW-1:0] first_reg;
    logic [SW-1:0] first_next;
    logic [SW-1:0] second_reg;
    logic [SW-1:0] second_next;
    logic [WW-1:0] magic_reg;
    logic [WW-1:0] magic_next;
    logic [WW-1:0] version_reg;
    logic [WW-1:0] version_next;
    logic [WW-1:0] length_reg;
    logic [WW-1:0] length_next;
    logic [WW-1:0] checksum_reg;
    logic [WW-1:0] checksum_next;

    logic          out_valid_reg;
    logic [15:0]   sum_reg;
    logic          hdr_reg;
    logic          sm_reg;
    logic          rv_reg;
    logic          short_reg;

    logic          in_accept;
    logic          out_accept;
    logic [PW:0]   end_pos;
    logic          pos_sat;
    logic [15:0]   sum_now;
    logic          hdr_now;
    logic          sm_now;
    logic          short_now;

    assign in_stall   = out_valid_reg && out_stall && end_of_record;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign end_pos    = (PW+1)'(HEADER_BYTES) + {1'b0, pay_len_reg};
    assign pos_sat    = &pos_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        magic_next    = magic_reg;
        version_next  = version_reg;
        length_next   = length_reg;
        checksum_next = checksum_reg;
        if (!pos_sat)
        begin
            pos_next = pos_reg + PW'(1);
            if (pos_reg < PW'(HEADER_BYTES))
            begin
                if (pos_reg < PW'(16))
                begin
                    unique case (sfv_pkg::hdr_word_t'(pos_reg[3:2]))
                        sfv_pkg::HDR_MAGIC:    magic_next[pos_reg[1:0]*8 +: 8] = data_byte;
                        sfv_pkg::HDR_VERSION:  version_next[pos_reg[1:0]*8 +: 8] = data_byte;
                        sfv_pkg::HDR_LENGTH:   length_next[pos_reg[1:0]*8 +: 8] = data_byte;
                        sfv_pkg::HDR_CHECKSUM: checksum_next[pos_reg[1:0]*8 +: 8] = data_byte;
                        default:               magic_next = magic_reg;
                    endcase
                end
            end
            else if ({1'b0, pos_reg} < end_pos)
            begin
                first_next  = sfv_pkg::mod255_add(first_reg, data_byte);
                second_next = sfv_pkg::mod255_add(second_reg, first_next);
            end
        end
    end

    assign sum_now   = {second_next, first_next};
    assign hdr_now   = (magic_next == exp_magic_reg) && (version_next == exp_version_reg)
                       && (length_next == {{(WW-PW){1'b0}}, pay_len_reg});
    assign sm_now    = checksum_next == {16'd0, sum_now};
    assign short_now = {1'b0, pos_next} < end_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
            pay_len_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sfv_pkg::CFG_MAGIC:   exp_magic_reg   <= cfg_data;
                sfv_pkg::CFG_VERSION: exp_version_reg <= cfg_data;
                sfv_pkg::CFG_LENGTH:  pay_len_reg     <= cfg_data[PW-1:0];
                default:              pay_len_reg     <= pay_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            magic_reg    <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            checksum_reg <= '0;
        end
        else if (in_accept)
        begin
            if (end_of_record)
            begin
                pos_reg      <= '0;
                first_reg    <= '0;
                second_reg   <= '0;
                magic_reg    <= '0;
                version_reg  <= '0;
                length_reg   <= '0;
                checksum_reg <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
                magic_reg    <= magic_next;
                version_reg  <= version_next;
                length_reg   <= length_next;
                checksum_reg <= checksum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && end_of_record)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && end_of_record)
        begin
            sum_reg   <= sum_now;
            hdr_reg   <= hdr_now;
            sm_reg    <= sm_now;
            rv_reg    <= hdr_now && sm_now && !short_now;
            short_reg <= short_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign computed_sum = sum_reg;
    assign header_match = hdr_reg;
    assign sum_match    = sm_reg;
    assign record_valid = rv_reg;
    assign stream_short = short_reg;

    // A last word always produces a verdict in the next cycle.
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_record |=> out_valid)
        else $error("verdict missing after last word");

    // The record state is rearmed after every verdict.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_record |=> pos_reg == '0 && first_reg == '0 && second_reg == '0)
        else $error("record state not rearmed");

    // The Fletcher sums stay proper residues modulo 255.
    a_residue: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg != sfv_pkg::FLETCHER_MOD && second_reg != sfv_pkg::FLETCHER_MOD)
        else $error("Fletcher sum out of range");

    // An overall pass requires every individual check to pass.
    a_valid_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_valid |-> header_match && sum_match && !stream_short)
        else $error("record_valid inconsistent with flags");

endmodule
